// ===== hdl/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared constants, types and helpers for the sequence duplicate filter.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  localparam int ID_W       = 64;
  localparam int BOOT_W     = 32;
  localparam int SEQ_W      = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id_high;
    logic [ID_W-1:0]   id_low;
    logic [BOOT_W-1:0] boot;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

  // Clear every id byte after the first zero byte, high half first.
  function automatic logic [2*ID_W-1:0] clean_id(input logic [2*ID_W-1:0] id);
    logic [2*ID_W-1:0] res;
    logic              ended;
    res   = id;
    ended = 1'b0;
    for (int b = 0; b < (2 * ID_W) / 8; b++) begin
      if (ended) begin
        res[2*ID_W-1-8*b -: 8] = 8'h00;
      end else if (id[2*ID_W-1-8*b -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/sequence_duplicate_filter_core.sv =====
// ----------------------------------------------------------------------------
// sequence_duplicate_filter_core
// Flags packets whose sender id, boot id and sequence were already seen.
// ----------------------------------------------------------------------------
// A checked packet walks a table of ENTRIES senders held in one synchronous
// RAM, one entry read per cycle. Its result word goes from ST_WALK through
// ST_WRITE (skipped for a duplicate) to ST_DONE and then into the output
// register; the input is ready again once the block is back in ST_IDLE.
// The walk stops early on a matching id; the single RAM read port, walked
// one entry a cycle, sets the length of the walk. An unchecked packet never
// touches the table: it goes from ST_IDLE straight to ST_DONE, which puts
// its result word in the output register once that is free. A result
// word that still waits unaccepted holds the block in its final state until
// the output side takes it. The id is cleaned on input (bytes after the first
// zero byte are cleared). A packet is a duplicate when an entry has the same
// id and boot id and a stored sequence at least as large; otherwise its id,
// boot id and sequence are written back to the matching entry, else the
// first empty entry (first id byte zero), else the entry at sequence modulo
// ENTRIES. Per-entry valid flops make the table read as all zero right after
// reset, so no clearing pass is needed. A new packet is taken while the
// previous result word still waits in the output register.
// ----------------------------------------------------------------------------
module sequence_duplicate_filter_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       checked_i,
  input  logic [sdf_pkg::ID_W-1:0]   hanger_id_high_i,
  input  logic [sdf_pkg::ID_W-1:0]   hanger_id_low_i,
  input  logic [sdf_pkg::BOOT_W-1:0] boot_id_i,
  input  logic [sdf_pkg::SEQ_W-1:0]  sequence_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       duplicate_o
);

  // control state
  sdf_pkg::state_e                 state_q, state_d;
  logic [sdf_pkg::CNT_W-1:0]       rd_cnt_q, rd_cnt_d;
  logic                            cmp_vld_q, cmp_vld_d;
  logic [sdf_pkg::IDX_W-1:0]       cmp_idx_q, cmp_idx_d;
  logic                            empty_found_q, empty_found_d;
  logic [sdf_pkg::ENTRIES-1:0]     entry_vld_q, entry_vld_d;
  logic                            out_valid_q, out_valid_d;
  logic                            rd_vld_q;

  // payload registers
  logic [sdf_pkg::ID_W-1:0]        id_high_q, id_high_d;
  logic [sdf_pkg::ID_W-1:0]        id_low_q, id_low_d;
  logic [sdf_pkg::BOOT_W-1:0]      boot_q, boot_d;
  logic [sdf_pkg::SEQ_W-1:0]       seq_q, seq_d;
  logic [sdf_pkg::IDX_W-1:0]       empty_idx_q, empty_idx_d;
  logic [sdf_pkg::IDX_W-1:0]       slot_q, slot_d;
  logic                            use_mod_q, use_mod_d;
  logic                            dup_q, dup_d;
  logic                            dup_out_q, dup_out_d;

  // table RAM
  sdf_pkg::entry_t                 entry_mem [sdf_pkg::ENTRIES];
  sdf_pkg::entry_t                 rd_data_q;
  sdf_pkg::entry_t                 wr_data;
  logic [sdf_pkg::IDX_W-1:0]       rd_idx;
  logic [sdf_pkg::IDX_W-1:0]       wr_idx;
  logic                            wr_en;

  // compare stage
  sdf_pkg::entry_t                 ent;
  logic                            id_hit;
  logic                            is_dup;
  logic                            ent_empty;
  logic                            walk_last;
  logic                            in_fire;
  logic                            out_free;
  logic [2*sdf_pkg::ID_W-1:0]      id_clean;

  assign in_fire  = in_valid_i && (state_q == sdf_pkg::ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;
  assign id_clean = sdf_pkg::clean_id({hanger_id_high_i, hanger_id_low_i});

  // An entry never written since reset reads as all zero.
  assign ent       = rd_vld_q ? rd_data_q : '0;
  assign id_hit    = cmp_vld_q && (ent.id_high == id_high_q) && (ent.id_low == id_low_q);
  assign is_dup    = id_hit && (ent.boot == boot_q) && (seq_q <= ent.seq);
  assign ent_empty = cmp_vld_q && (ent.id_high[sdf_pkg::ID_W-1 -: 8] == 8'h00);
  assign walk_last = cmp_vld_q && (cmp_idx_q == sdf_pkg::IDX_W'(sdf_pkg::ENTRIES - 1));

  // Table full: evict the entry at sequence modulo ENTRIES.
  assign wr_data = '{id_high: id_high_q, id_low: id_low_q, boot: boot_q, seq: seq_q};
  assign rd_idx  = rd_cnt_q[sdf_pkg::IDX_W-1:0];
  assign wr_idx  = use_mod_q ? sdf_pkg::IDX_W'(seq_q % sdf_pkg::ENTRIES) : slot_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdf_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = checked_i ? sdf_pkg::ST_WALK : sdf_pkg::ST_DONE;
        end
      end
      sdf_pkg::ST_WALK: begin
        if (id_hit) begin
          state_d = is_dup ? sdf_pkg::ST_DONE : sdf_pkg::ST_WRITE;
        end else if (walk_last) begin
          state_d = sdf_pkg::ST_WRITE;
        end
      end
      sdf_pkg::ST_WRITE: begin
        state_d = sdf_pkg::ST_DONE;
      end
      sdf_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = sdf_pkg::ST_IDLE;
        end
      end
      default: state_d = sdf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    rd_cnt_d      = rd_cnt_q;
    cmp_vld_d     = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    empty_found_d = empty_found_q;
    empty_idx_d   = empty_idx_q;
    entry_vld_d   = entry_vld_q;
    out_valid_d   = out_valid_q;
    dup_out_d     = dup_out_q;
    id_high_d     = id_high_q;
    id_low_d      = id_low_q;
    boot_d        = boot_q;
    seq_d         = seq_q;
    slot_d        = slot_q;
    use_mod_d     = use_mod_q;
    dup_d         = dup_q;
    wr_en         = 1'b0;

    // drop the result word once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      sdf_pkg::ST_IDLE: begin
        if (in_fire) begin
          id_high_d     = id_clean[2*sdf_pkg::ID_W-1 -: sdf_pkg::ID_W];
          id_low_d      = id_clean[sdf_pkg::ID_W-1:0];
          boot_d        = boot_id_i;
          seq_d         = sequence_req_i;
          dup_d         = 1'b0;
          use_mod_d     = 1'b0;
          rd_cnt_d      = '0;
          empty_found_d = 1'b0;
        end
      end
      sdf_pkg::ST_WALK: begin
        // issue the next read while comparing the previous one
        if (rd_cnt_q < sdf_pkg::CNT_W'(sdf_pkg::ENTRIES)) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx;
          rd_cnt_d  = rd_cnt_q + 1'b1;
        end
        if (ent_empty && !empty_found_q) begin
          empty_found_d = 1'b1;
          empty_idx_d   = cmp_idx_q;
        end
        if (id_hit) begin
          cmp_vld_d = 1'b0;
          dup_d     = is_dup;
          slot_d    = cmp_idx_q;
          use_mod_d = 1'b0;
        end else if (walk_last) begin
          cmp_vld_d = 1'b0;
          if (empty_found_q) begin
            slot_d    = empty_idx_q;
            use_mod_d = 1'b0;
          end else if (ent_empty) begin
            slot_d    = cmp_idx_q;
            use_mod_d = 1'b0;
          end else begin
            use_mod_d = 1'b1;
          end
        end
      end
      sdf_pkg::ST_WRITE: begin
        wr_en               = 1'b1;
        entry_vld_d[wr_idx] = 1'b1;
      end
      sdf_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          dup_out_d   = dup_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == sdf_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign duplicate_o = dup_out_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= sdf_pkg::ST_IDLE;
      rd_cnt_q      <= '0;
      cmp_vld_q     <= 1'b0;
      empty_found_q <= 1'b0;
      entry_vld_q   <= '0;
      out_valid_q   <= 1'b0;
      rd_vld_q      <= 1'b0;
    end else begin
      state_q       <= state_d;
      rd_cnt_q      <= rd_cnt_d;
      cmp_vld_q     <= cmp_vld_d;
      empty_found_q <= empty_found_d;
      entry_vld_q   <= entry_vld_d;
      out_valid_q   <= out_valid_d;
      rd_vld_q      <= entry_vld_q[rd_idx];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    empty_idx_q <= empty_idx_d;
    id_high_q   <= id_high_d;
    id_low_q    <= id_low_d;
    boot_q      <= boot_d;
    seq_q       <= seq_d;
    slot_q      <= slot_d;
    use_mod_q   <= use_mod_d;
    dup_q       <= dup_d;
    dup_out_q   <= dup_out_d;
  end

  // Table RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[wr_idx] <= wr_data;
    end
    rd_data_q <= entry_mem[rd_idx];
  end

endmodule
